// ===== sv/u8u16_pkg.sv =====
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 transcoder: the result
// record, the terminator status codes and the output queue default depth.
// ----------------------------------------------------------------------------
`default_nettype none

package u8u16_pkg;

    // Status carried on the terminator unit.
    typedef enum logic [1:0] {
        END_OK       = 2'd0,
        END_BAD_LEAD = 2'd1,
        END_TRUNC    = 2'd2,
        END_LIMIT    = 2'd3
    } end_status_t;

    // One result request on the output channel.
    typedef struct packed {
        logic [15:0] code_unit;
        logic        is_end;
        logic [1:0]  end_status;
    } result_t;

    // Up to two results produced by one input byte.
    typedef struct packed {
        logic    valid0;
        logic    valid1;
        result_t res0;
        result_t res1;
    } push_t;

    // Surrogate and UTF-8 constants.
    localparam logic [26:0] SUPPLEMENTARY_BASE = 27'h10000;
    localparam logic [15:0] HIGH_SURROGATE     = 16'hD800;
    localparam logic [5:0]  LOW_SURROGATE_TOP  = 6'b110111;

    // Default depth of the output queue (power of two, at least 4).
    localparam int OUTQ_DEPTH_DEFAULT = 8;

endpackage

`default_nettype wire

// ===== sv/u8u16_decode.sv =====
// ----------------------------------------------------------------------------
// u8u16_decode
// Per-byte decoder: holds the partial code point and string state, and turns
// one registered byte into zero, one or two result requests.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_decode
    import u8u16_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    input  wire logic [7:0]  item_byte,
    input  wire logic [23:0] code_limit,
    output push_t            push
);

    logic [20:0]  partial_reg,  partial_next;
    logic [1:0]   pending_reg,  pending_next;
    logic [2:0]   seqlen_reg,   seqlen_next;
    logic         halted_reg,   halted_next;
    end_status_t  hstatus_reg,  hstatus_next;
    logic [23:0]  done_reg,     done_next;

    logic         fin;
    logic [20:0]  fin_code;
    logic [2:0]   fin_len;
    logic [20:0]  ext_code;
    logic [26:0]  sur_diff;
    logic [23:0]  done_inc;
    end_status_t  term_status;

    // Continuation byte appended to the partial code point.
    assign ext_code = {partial_reg[14:0], item_byte[5:0]};
    // Offset into the supplementary planes for a surrogate pair.
    assign sur_diff = {6'b0, fin_code} - SUPPLEMENTARY_BASE;
    assign done_inc = done_reg + 24'd1;

    // Status of a terminator given the current string state.
    always_comb
    begin
        if (halted_reg)
        begin
            term_status = hstatus_reg;
        end
        else if (pending_reg != 2'd0)
        begin
            term_status = END_TRUNC;
        end
        else
        begin
            term_status = END_OK;
        end
    end

    // Next-state and result logic for one byte.
    always_comb
    begin
        partial_next = partial_reg;
        pending_next = pending_reg;
        seqlen_next  = seqlen_reg;
        halted_next  = halted_reg;
        hstatus_next = hstatus_reg;
        done_next    = done_reg;
        fin          = 1'b0;
        fin_code     = '0;
        fin_len      = '0;
        push         = '0;

        if (item_valid)
        begin
            if (item_byte == 8'd0)
            begin
                push.valid0          = 1'b1;
                push.res0.code_unit  = 16'd0;
                push.res0.is_end     = 1'b1;
                push.res0.end_status = term_status;
                partial_next = '0;
                pending_next = '0;
                seqlen_next  = '0;
                halted_next  = 1'b0;
                hstatus_next = END_OK;
                done_next    = '0;
            end
            else if (!halted_reg)
            begin
                if (pending_reg != 2'd0)
                begin
                    partial_next = ext_code;
                    pending_next = pending_reg - 2'd1;
                    if (pending_reg == 2'd1)
                    begin
                        fin      = 1'b1;
                        fin_code = ext_code;
                        fin_len  = seqlen_reg;
                    end
                end
                else if (item_byte[7] == 1'b0)
                begin
                    fin      = 1'b1;
                    fin_code = {13'd0, item_byte};
                    fin_len  = 3'd1;
                end
                else if (item_byte[7:5] == 3'b110)
                begin
                    partial_next = {16'd0, item_byte[4:0]};
                    seqlen_next  = 3'd2;
                    pending_next = 2'd1;
                end
                else if (item_byte[7:4] == 4'b1110)
                begin
                    partial_next = {17'd0, item_byte[3:0]};
                    seqlen_next  = 3'd3;
                    pending_next = 2'd2;
                end
                else if (item_byte[7:3] == 5'b11110)
                begin
                    partial_next = {18'd0, item_byte[2:0]};
                    seqlen_next  = 3'd4;
                    pending_next = 2'd3;
                end
                else
                begin
                    halted_next  = 1'b1;
                    hstatus_next = END_BAD_LEAD;
                end
            end
        end

        // A completed code point: emit its unit or surrogate pair and count it.
        if (fin)
        begin
            partial_next = '0;
            seqlen_next  = '0;
            pending_next = '0;
            done_next    = done_inc;
            if ((code_limit != 24'd0) && (done_inc >= code_limit))
            begin
                halted_next  = 1'b1;
                hstatus_next = END_LIMIT;
            end
            push.valid0 = 1'b1;
            if (fin_len == 3'd4)
            begin
                push.valid1          = 1'b1;
                push.res0.code_unit  = sur_diff[25:10] + HIGH_SURROGATE;
                push.res1.code_unit  = {LOW_SURROGATE_TOP, sur_diff[9:0]};
            end
            else
            begin
                push.res0.code_unit  = fin_code[15:0];
            end
        end
    end

    // String state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            pending_reg <= '0;
            seqlen_reg  <= '0;
            halted_reg  <= 1'b0;
            hstatus_reg <= END_OK;
            done_reg    <= '0;
        end
        else
        begin
            partial_reg <= partial_next;
            pending_reg <= pending_next;
            seqlen_reg  <= seqlen_next;
            halted_reg  <= halted_next;
            hstatus_reg <= hstatus_next;
            done_reg    <= done_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/u8u16_outq.sv =====
// ----------------------------------------------------------------------------
// u8u16_outq
// Result queue: takes up to two requests per cycle from the decoder and
// hands one per cycle to the output channel while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_outq
    import u8u16_pkg::*;
#(
    parameter int DEPTH = OUTQ_DEPTH_DEFAULT
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire push_t push,
    output logic       room,
    output logic       out_valid,
    input  wire logic  out_ready,
    output result_t    out_res
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] ROOM_LIMIT = CW'(DEPTH - 4);

    result_t         mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg,  count_next;
    logic [PW-1:0]   wr_ptr_plus1;
    logic            pop;
    logic [CW-1:0]   push_cnt;

    assign out_valid    = (count_reg != '0);
    assign out_res      = mem[rd_ptr_reg];
    assign pop          = out_valid && out_ready;
    // Room for two items still in flight plus two more requests.
    assign room         = (count_reg <= ROOM_LIMIT);
    assign wr_ptr_plus1 = wr_ptr_reg + PW'(1);
    assign push_cnt     = CW'({1'b0, push.valid0}) + CW'({1'b0, push.valid1});

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(push_cnt);
        rd_ptr_next = pop ? (rd_ptr_reg + PW'(1)) : rd_ptr_reg;
        count_next  = count_reg + push_cnt - CW'({1'b0, pop});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push.valid0)
        begin
            mem[wr_ptr_reg] <= push.res0;
        end
        if (push.valid1)
        begin
            mem[wr_ptr_plus1] <= push.res1;
        end
    end

endmodule

`default_nettype wire

// ===== sv/utf8_to_utf16_transcoder.sv =====
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// Streaming UTF-8 to UTF-16 converter with string terminator status and a
// configurable code point limit.
// ----------------------------------------------------------------------------
//
//  Channel  Signals                             Direction  Moves
//  in       in_valid/in_ready, in_byte          input      one UTF-8 byte
//  out      out_valid/out_ready, code_unit,     output     one UTF-16 unit or
//           is_end, end_status                             terminator
//  cfg      cfg_we, cfg_wdata                   input      code_limit write
//
//  A byte is registered when accepted, decoded in the next cycle and its
//  results are registered into the output queue, from which the first result
//  is then visible. One byte per cycle is taken sustained; a byte is taken
//  while the output queue holds at most DEPTH-4 requests, so a stalled
//  output side stops input once the queue fills. Reset clears all string
//  state, the queue and code_limit.
//
`default_nettype none

module utf8_to_utf16_transcoder
    import u8u16_pkg::*;
#(
    parameter int OUTQ_DEPTH = OUTQ_DEPTH_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      code_unit,
    output logic             is_end,
    output logic [1:0]       end_status,
    input  wire logic        cfg_we,
    input  wire logic [23:0] cfg_wdata
);

    logic        item_valid_reg;
    logic [7:0]  item_byte_reg;
    logic [23:0] code_limit_reg;
    push_t       push;
    logic        room;
    result_t     out_res;

    assign in_ready   = room;
    assign code_unit  = out_res.code_unit;
    assign is_end     = out_res.is_end;
    assign end_status = out_res.end_status;

    // Input register and configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            code_limit_reg <= '0;
        end
        else
        begin
            item_valid_reg <= in_valid && in_ready;
            if (cfg_we)
            begin
                code_limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_byte_reg <= in_byte;
        end
    end

    // Byte decoder with string state.
    u8u16_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid_reg),
        .item_byte  (item_byte_reg),
        .code_limit (code_limit_reg),
        .push       (push)
    );

    // Result queue toward the output channel.
    u8u16_outq #(
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

endmodule

`default_nettype wire
